FILE: rtl/srr_pkg.sv
// Shared constants, types and helper functions for the selective-repeat receiver.
// No dependencies; imported by selective_repeat_receiver_unit.
package srr_pkg;

    // Packet word layout
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned PAYLOAD_W  = 27;
    localparam int unsigned SEQ_W      = 3;
    localparam int unsigned SEQ_SPACE  = 8;
    localparam int unsigned END_BIT    = 27;
    localparam int unsigned SEQ_LSB    = 28;
    localparam int unsigned ACK_W      = 4;
    localparam int unsigned IDX_W      = 16;
    localparam int unsigned KIND_W     = 2;

    // Output beat: payload, seq, ack, index packed from bit 0, padded to bytes
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned OUT_USED_W = PAYLOAD_W + SEQ_W + ACK_W + IDX_W;

    // Default receive window
    localparam int unsigned WINDOW_DEF = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DRAIN = 5'b00010,
        ST_DELIV = 5'b00100,
        ST_ACK   = 5'b01000,
        ST_END   = 5'b10000
    } t_state;

    // Ack word: sequence in bits 3-1, even parity in bit 0
    function automatic logic [ACK_W-1:0] ack_of(input logic [SEQ_W-1:0] seq);
        ack_of = {seq, ^seq};
    endfunction

endpackage

FILE: rtl/selective_repeat_receiver_unit.sv
// Selective-repeat ARQ receiver: reorder memory, in-order drain and ack generation.
// Depends on srr_pkg for layout constants, result kinds and state codes.
//
// Takes one 32-bit packet word per input beat (bit 31 parity, bits 30-28
// sequence, bit 27 end flag, bits 26-0 payload). A word with odd parity is
// dropped with no output. An end packet gives one END beat and touches no
// state. A data packet whose sequence lies within WINDOW slots of the expected
// sequence is written into an 8-entry reorder memory unless that slot is
// already held; the block then releases up to WINDOW held payloads in order
// (DATA beats carrying slot, payload and a running 16-bit delivery index) and
// closes with one ACK beat. tlast marks the final beat of each packet. The
// reorder memory has a registered read. From acceptance to its ack being
// loaded, a data packet goes through these steps in order: store, look up the
// expected slot and start its read, a delivery step for each drained payload
// (0..WINDOW of them; the read of the next slot overlaps the current
// delivery), and the ack. A new packet is accepted only when the previous
// one has been fully handed to the output register, which may still hold
// its last beat. Stalls on m_axis_tready hold back the DATA, ACK and END beats.
module selective_repeat_receiver_unit
    import srr_pkg::*;
#(
    parameter int unsigned WINDOW = WINDOW_DEF   // receive window, 1..4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input packets
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,   // [31:0] packet_word
    // Results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [26:0] payload, [29:27] seq_number, [33:30] ack_word,
    // [49:34] delivery_index, [55:50] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] result_kind
    output logic                  m_axis_tlast
);

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);

    // Control state
    t_state                 r_state, n_state;
    logic [SEQ_W-1:0]       r_exp, n_exp;           // next sequence to deliver
    logic [SEQ_SPACE-1:0]   r_held, n_held;         // slot holds a payload
    logic [IDX_W-1:0]       r_count, n_count;       // delivered payloads
    logic [SEQ_W-1:0]       r_seq, n_seq;           // sequence of packet in work
    logic [CNT_W-1:0]       r_drain_cnt, n_drain_cnt;

    // Reorder memory with registered read port
    logic [PAYLOAD_W-1:0]   r_mem [SEQ_SPACE];
    logic [PAYLOAD_W-1:0]   r_rd_data;
    logic                   w_wr_en;
    logic                   w_rd_en;
    logic [SEQ_W-1:0]       w_rd_addr;

    // Output register
    logic                   r_m_valid, n_m_valid;
    t_kind                  r_m_kind, n_m_kind;
    logic [PAYLOAD_W-1:0]   r_m_payload, n_m_payload;
    logic [SEQ_W-1:0]       r_m_seq, n_m_seq;
    logic [ACK_W-1:0]       r_m_ack, n_m_ack;
    logic [IDX_W-1:0]       r_m_idx, n_m_idx;
    logic                   r_m_last, n_m_last;

    // Input decode
    logic                   w_par_ok;
    logic                   w_is_end;
    logic [SEQ_W-1:0]       w_in_seq;
    logic [PAYLOAD_W-1:0]   w_in_payload;
    logic [SEQ_W-1:0]       w_dist;
    logic                   w_in_window;
    logic                   w_accept;
    logic                   w_out_free;
    logic [SEQ_W-1:0]       w_exp_inc;
    logic [CNT_W-1:0]       w_cnt_inc;
    logic                   w_more;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_par_ok     = ~(^s_axis_tdata);
    assign w_is_end     = s_axis_tdata[END_BIT];
    assign w_in_seq     = s_axis_tdata[SEQ_LSB +: SEQ_W];
    assign w_in_payload = s_axis_tdata[PAYLOAD_W-1:0];
    assign w_dist       = w_in_seq - r_exp;
    assign w_in_window  = ({1'b0, w_dist} < (SEQ_W + 1)'(WINDOW));

    assign w_out_free = !r_m_valid || m_axis_tready;
    assign w_exp_inc  = r_exp + SEQ_W'(1);
    assign w_cnt_inc  = r_drain_cnt + CNT_W'(1);
    // Keep draining while the next slot is held and the window is not used up
    assign w_more     = r_held[w_exp_inc] && (w_cnt_inc < CNT_W'(WINDOW));

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_held      = r_held;
        n_count     = r_count;
        n_seq       = r_seq;
        n_drain_cnt = r_drain_cnt;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_exp;

        // Drop the output beat once taken
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_m_kind    = r_m_kind;
        n_m_payload = r_m_payload;
        n_m_seq     = r_m_seq;
        n_m_ack     = r_m_ack;
        n_m_idx     = r_m_idx;
        n_m_last    = r_m_last;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_par_ok) begin
                    if (w_is_end) begin
                        n_state = ST_END;
                    end else begin
                        n_seq       = w_in_seq;
                        n_drain_cnt = '0;
                        // Store only new in-window packets; duplicates keep the old payload
                        if (w_in_window && !r_held[w_in_seq]) begin
                            w_wr_en          = 1'b1;
                            n_held[w_in_seq] = 1'b1;
                        end
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Look up the expected slot; the write of the last cycle is visible now
                if (r_held[r_exp]) begin
                    w_rd_en       = 1'b1;
                    n_held[r_exp] = 1'b0;
                    n_state       = ST_DELIV;
                end else begin
                    n_state = ST_ACK;
                end
            end
            ST_DELIV: begin
                if (w_out_free) begin
                    n_m_valid   = 1'b1;
                    n_m_kind    = KIND_DATA;
                    n_m_payload = r_rd_data;
                    n_m_seq     = r_exp;
                    n_m_ack     = '0;
                    n_m_idx     = r_count;
                    n_m_last    = 1'b0;
                    n_count     = r_count + IDX_W'(1);
                    n_exp       = w_exp_inc;
                    n_drain_cnt = w_cnt_inc;
                    // Overlap the read of the following slot with this delivery
                    if (w_more) begin
                        w_rd_en           = 1'b1;
                        w_rd_addr         = w_exp_inc;
                        n_held[w_exp_inc] = 1'b0;
                    end else begin
                        n_state = ST_ACK;
                    end
                end
            end
            ST_ACK: begin
                if (w_out_free) begin
                    n_m_valid   = 1'b1;
                    n_m_kind    = KIND_ACK;
                    n_m_payload = '0;
                    n_m_seq     = r_seq;
                    n_m_ack     = ack_of(r_seq);
                    n_m_idx     = '0;
                    n_m_last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_END: begin
                if (w_out_free) begin
                    n_m_valid   = 1'b1;
                    n_m_kind    = KIND_END;
                    n_m_payload = '0;
                    n_m_seq     = '0;
                    n_m_ack     = '0;
                    n_m_idx     = '0;
                    n_m_last    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Reorder memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_in_seq] <= w_in_payload;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_exp       <= '0;
            r_held      <= '0;
            r_count     <= '0;
            r_drain_cnt <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_held      <= n_held;
            r_count     <= n_count;
            r_drain_cnt <= n_drain_cnt;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq       <= n_seq;
        r_m_kind    <= n_m_kind;
        r_m_payload <= n_m_payload;
        r_m_seq     <= n_m_seq;
        r_m_ack     <= n_m_ack;
        r_m_idx     <= n_m_idx;
        r_m_last    <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), r_m_idx, r_m_ack, r_m_seq,
                            r_m_payload};

    // Only ack and end beats close a packet
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_DATA)))
        else $error("tlast does not match result kind");

    // The slot being delivered has already had its held mark released
    a_deliv_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELIV) |-> !r_held[r_exp])
        else $error("delivering slot still marked held");

    // Drain never exceeds the window
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain_cnt <= CNT_W'(WINDOW))
        else $error("drain count beyond window");

    // Every data beat loaded advances the delivery count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DELIV && w_out_free) |=> (r_count == $past(r_count) + IDX_W'(1)))
        else $error("delivery count did not advance");

endmodule

FILE: dv/tb_selective_repeat_receiver_unit.sv
// Self-checking testbench for selective_repeat_receiver_unit: drives packet words,
// predicts every result beat and compares it field by field as it leaves the block.
// Depends on srr_pkg and rtl/selective_repeat_receiver_unit.sv only.
module tb_selective_repeat_receiver_unit;
    import srr_pkg::*;

    localparam int unsigned RX_WINDOW  = WINDOW_DEF;
    localparam int unsigned MAX_PRINTS = 40;

    // One predicted result beat
    typedef struct {
        t_kind                kind;
        logic [PAYLOAD_W-1:0] payload;
        logic [SEQ_W-1:0]     seq;
        logic [ACK_W-1:0]     ack;
        logic [IDX_W-1:0]     idx;
        logic                 last;
    } t_srr_result;

    // Receiver model plus the queue of beats it still owes
    class srr_scoreboard;
        logic [SEQ_W-1:0]     next_seq;
        bit                   held [SEQ_SPACE];
        logic [PAYLOAD_W-1:0] slots [SEQ_SPACE];
        logic [IDX_W-1:0]     deliv_cnt;
        t_srr_result          owed_q [$];
        int                   errors;
        int                   beat_no;

        function new();
            next_seq  = '0;
            deliv_cnt = '0;
            errors    = 0;
            beat_no   = 0;
            foreach (held[i]) begin
                held[i]  = 1'b0;
                slots[i] = '0;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function void owe(t_kind k, logic [PAYLOAD_W-1:0] pay, logic [SEQ_W-1:0] s,
                          logic [ACK_W-1:0] a, logic [IDX_W-1:0] ix, logic lst);
            t_srr_result r;
            r.kind    = k;
            r.payload = pay;
            r.seq     = s;
            r.ack     = a;
            r.idx     = ix;
            r.last    = lst;
            owed_q.push_back(r);
        endfunction

        // Update the model for one accepted packet word
        function void note_packet(logic [WORD_W-1:0] w);
            logic [SEQ_W-1:0] s;
            logic [SEQ_W-1:0] seq_gap;
            int               n;
            if (^w)
                return;                         // odd ones count: dropped silently
            if (w[END_BIT]) begin
                owe(KIND_END, '0, '0, '0, '0, 1'b1);
                return;
            end
            s       = w[SEQ_LSB +: SEQ_W];
            seq_gap = s - next_seq;             // wraps in the 8-entry sequence space
            if (seq_gap < RX_WINDOW && !held[s]) begin
                slots[s] = w[PAYLOAD_W-1:0];
                held[s]  = 1'b1;
            end
            for (n = 0; n < RX_WINDOW && held[next_seq]; n++) begin
                held[next_seq] = 1'b0;
                owe(KIND_DATA, slots[next_seq], next_seq, '0, deliv_cnt, 1'b0);
                deliv_cnt++;
                next_seq++;
            end
            owe(KIND_ACK, '0, s, {s, ^s}, '0, 1'b1);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch at beat %0d: %s", $realtime, beat_no, msg);
            errors++;
        endtask

        // Compare one accepted result beat against the oldest owed beat
        task check_beat(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data, logic lst);
            t_srr_result want;
            beat_no++;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind %0d data %h", kind, data));
                return;
            end
            want = owed_q.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (data[PAYLOAD_W-1:0] !== want.payload)
                report_mismatch($sformatf("payload %h, want %h",
                                          data[PAYLOAD_W-1:0], want.payload));
            if (data[PAYLOAD_W +: SEQ_W] !== want.seq)
                report_mismatch($sformatf("seq %0d, want %0d",
                                          data[PAYLOAD_W +: SEQ_W], want.seq));
            if (data[PAYLOAD_W+SEQ_W +: ACK_W] !== want.ack)
                report_mismatch($sformatf("ack %h, want %h",
                                          data[PAYLOAD_W+SEQ_W +: ACK_W], want.ack));
            if (data[PAYLOAD_W+SEQ_W+ACK_W +: IDX_W] !== want.idx)
                report_mismatch($sformatf("index %0d, want %0d",
                                          data[PAYLOAD_W+SEQ_W+ACK_W +: IDX_W], want.idx));
            if (data[OUT_DATA_W-1:OUT_USED_W] !== '0)
                report_mismatch($sformatf("pad bits %h not zero",
                                          data[OUT_DATA_W-1:OUT_USED_W]));
            if (lst !== want.last)
                report_mismatch($sformatf("tlast %b, want %b", lst, want.last));
        endtask

        task check_leftovers();
            while (owed_q.size() != 0) begin
                report_mismatch($sformatf("beat kind %0d seq %0d never arrived",
                                          owed_q[0].kind, owed_q[0].seq));
                void'(owed_q.pop_front());
            end
        endtask
    endclass

    // Clock, reset and bus signals; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata  = '0;   // [31:0] packet_word
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [26:0] payload, [29:27] seq,
                                                 // [33:30] ack, [49:34] index
    logic [KIND_W-1:0]     m_axis_tuser;         // [1:0] result_kind
    logic                  m_axis_tlast;

    srr_scoreboard sb;
    int unsigned   tx_idle_pct  = 33;
    int unsigned   rx_idle_pct  = 60;
    int            rx_hold_left = 0;

    always #10 i_clk = ~i_clk;

    selective_repeat_receiver_unit #(
        .WINDOW (RX_WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Result side: check the beat taken at this edge, then pick the next tready.
    // A pending hold-off keeps tready low for its whole count.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Build a packet word; parity bit makes the ones count even unless corrupt is set
    function automatic logic [WORD_W-1:0] make_word(bit is_end, logic [SEQ_W-1:0] s,
                                                    logic [PAYLOAD_W-1:0] pay, bit corrupt);
        logic [WORD_W-1:0] w;
        w = {1'b0, s, is_end, pay};
        w[WORD_W-1] = ^w[WORD_W-2:0] ^ corrupt;
        return w;
    endfunction

    // Offer one beat, idling first at the current rate; note it once accepted
    task automatic send_word(logic [WORD_W-1:0] w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_packet(w);
    endtask

    // Drop tvalid and hold off until every owed beat has come out
    task automatic wait_all_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(make_word(0, 3'd0, 27'h0000001, 1));   // bad parity: no beat
        send_word(make_word(1, 3'd7, 27'h7FFFFFF, 0));   // end of transmission
        send_word(make_word(1, 3'd0, 27'h0000000, 1));   // end with bad parity: dropped
        send_word(make_word(0, 3'd0, 27'h7FFFFFF, 0));   // in order, delivered at once
        send_word(make_word(0, 3'd1, 27'h0000000, 0));
        send_word(make_word(0, 3'd3, 27'h2AAAAAA, 0));   // ahead of a hole: stored
        send_word(make_word(0, 3'd4, 27'h5555555, 0));
        send_word(make_word(0, 3'd5, 27'h1234567, 0));
        send_word(make_word(0, 3'd4, 27'h0ABCDEF, 0));   // duplicate: first copy kept
        send_word(make_word(0, 3'd6, 27'h7654321, 0));   // just past the window edge
        send_word(make_word(0, 3'd1, 27'h3333333, 0));   // old retransmit, behind window
        send_word(make_word(0, 3'd2, 27'h4444444, 0));   // fills hole: drains four
        send_word(make_word(1, 3'd3, 27'h6DB6DB6, 0));   // end packet mid-stream
        send_word(make_word(0, 3'd7, 27'h0F0F0F0, 0));
        send_word(make_word(0, 3'd6, 27'h70F0F0F, 0));   // drains 6 and 7
        send_word(make_word(0, 3'd0, 27'h1111111, 0));   // sequence wraps to 0
        send_word(32'hFFFF_FFFF);                        // all ones: good end packet
        send_word(32'h0000_0000);                        // all zeros: seq 0 behind window
        send_word(32'h7FFF_FFFF);                        // odd ones count: dropped
    endtask

    // Shuffled subset of the current window: holes and reordering
    task automatic send_burst(output int sent);
        logic [SEQ_W-1:0] base;
        int unsigned      order [RX_WINDOW];
        int unsigned      len;
        int unsigned      pick;
        int unsigned      tmp;
        base = sb.next_seq;
        foreach (order[i])
            order[i] = i;
        for (int i = RX_WINDOW - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        len = $urandom_range(1, RX_WINDOW);
        for (int i = 0; i < len; i++)
            send_word(make_word(0, base + SEQ_W'(order[i]), PAYLOAD_W'($urandom), 0));
        sent = len;
    endtask

    // One random step; sent counts the beats that the block does not just drop
    task automatic random_step(output int sent);
        logic [WORD_W-1:0] w;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            send_burst(sent);
        end else if (r < 65) begin
            send_word(make_word(0, sb.next_seq + SEQ_W'($urandom_range(0, 3)),
                                PAYLOAD_W'($urandom), 0));
            sent = 1;
        end else if (r < 77) begin
            send_word(make_word(0, sb.next_seq + SEQ_W'($urandom_range(4, 7)),
                                PAYLOAD_W'($urandom), 0));
            sent = 1;
        end else if (r < 85) begin
            send_word(make_word(1, SEQ_W'($urandom), PAYLOAD_W'($urandom), 0));
            sent = 1;
        end else begin
            w = $urandom;                       // raw noise, about half fail parity
            send_word(w);
            sent = (^w) ? 0 : 1;
        end
    endtask

    task automatic random_phase(int target);
        int done;
        int n;
        done = 0;
        while (done < target) begin
            random_step(n);
            done += n;
        end
    endtask

    // Main sequence
    initial begin
        int wait_cycles;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_all_done();

        // Hold the result side off for a long stretch while packets keep coming,
        // so the output register fills and the block stalls its input
        tx_idle_pct  = 0;
        rx_hold_left = 300;
        for (int i = 0; i < 12; i++)
            send_word(make_word(0, sb.next_seq, PAYLOAD_W'($urandom), 0));
        wait_all_done();

        tx_idle_pct = 33;
        rx_idle_pct = 60;
        random_phase(130);
        wait_all_done();

        tx_idle_pct = 60;
        rx_idle_pct = 33;
        random_phase(130);
        wait_all_done();

        // Flat out on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(140);

        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        sb.check_leftovers();

        if (sb.errors == 0)
            $display("** selective_repeat_receiver_unit: PASSED **");
        else
            $display("** selective_repeat_receiver_unit: FAILED **");
        $finish;
    end

    // Watchdog: fails the run if it is still going at the time limit
    initial begin
        #(64'd2_000_000);
        $display("** selective_repeat_receiver_unit: FAILED **");
        $finish;
    end

endmodule

FILE: selective_repeat_receiver_unit.f
rtl/srr_pkg.sv
rtl/selective_repeat_receiver_unit.sv
dv/tb_selective_repeat_receiver_unit.sv
